/* src/assert_macros.svh */
// assertion macros used by the checker file
// depends on a clk and an active-low rst_n in the scope of use
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled in reset
`define ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("same-cycle check failed");

// next-cycle implication, disabled in reset
`define ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("next-cycle check failed");

`endif

/* src/dtx_pkg.sv */
// shared types and constants for the two-seed distance transform
// no dependencies
package dtx_pkg;

  localparam int DTX_ROWS  = 8;
  localparam int DTX_COLS  = 8;
  localparam int DTX_POS_W = 3;
  localparam int DTX_VAL_W = 4;
  localparam int DTX_IN_W  = 4;
  localparam int DTX_NBR   = 8;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_GROW,
    ST_EMIT,
    ST_ERR
  } dtx_state_t;

  typedef struct packed {
    logic load;
    logic grow;
    logic shift;
  } dtx_ctl_t;

endpackage

/* src/dtx_cell.sv */
// one grid cell: seed load, generation update from eight neighbors, readout shift
// depends on dtx_pkg
module dtx_cell (
  input  logic                                                clk,
  input  logic                                                rst_n,
  input  dtx_pkg::dtx_ctl_t                                   ctl,
  input  logic                                                seed,
  input  logic [dtx_pkg::DTX_NBR-1:0][dtx_pkg::DTX_VAL_W-1:0] nbr_val,
  input  logic [dtx_pkg::DTX_VAL_W-1:0]                       shift_in,
  output logic [dtx_pkg::DTX_VAL_W-1:0]                       val
);

  logic [dtx_pkg::DTX_VAL_W-1:0] val_r;
  logic [dtx_pkg::DTX_VAL_W-1:0] val_nxt;
  logic [dtx_pkg::DTX_VAL_W-1:0] best;

  // smallest nonzero neighbor, zero if none
  always_comb begin
    best = '0;
    for (int i = 0; i < dtx_pkg::DTX_NBR; i++) begin
      if (nbr_val[i] != '0 && (best == '0 || nbr_val[i] < best)) begin
        best = nbr_val[i];
      end
    end
  end

  always_comb begin
    val_nxt = val_r;
    if (ctl.load) begin
      val_nxt = seed ? dtx_pkg::DTX_VAL_W'(1) : '0;
    end else if (ctl.grow) begin
      if (val_r == '0 && best != '0) begin
        val_nxt = dtx_pkg::DTX_VAL_W'(best + dtx_pkg::DTX_VAL_W'(1));
      end
    end else if (ctl.shift) begin
      val_nxt = shift_in;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      val_r <= '0;
    end else begin
      val_r <= val_nxt;
    end
  end

  assign val = val_r;

endmodule

/* src/dtx_ctrl.sv */
// sequencer: seed, grow generations until the grid is full, then emit cells; bad seeds give one error result
// depends on dtx_pkg
module dtx_ctrl #(
  parameter int ROWS = dtx_pkg::DTX_ROWS,
  parameter int COLS = dtx_pkg::DTX_COLS
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  input  logic                          seeds_ok,
  input  logic                          grid_full,
  input  logic                          out_ready,
  output logic                          in_ready,
  output logic                          out_valid,
  output logic                          out_err,
  output logic                          out_last,
  output logic [dtx_pkg::DTX_POS_W-1:0] row,
  output logic [dtx_pkg::DTX_POS_W-1:0] col,
  output dtx_pkg::dtx_ctl_t             ctl
);

  dtx_pkg::dtx_state_t state_r, state_nxt;
  logic [dtx_pkg::DTX_POS_W-1:0] row_r, row_nxt;
  logic [dtx_pkg::DTX_POS_W-1:0] col_r, col_nxt;
  logic at_end;

  assign at_end = (row_r == dtx_pkg::DTX_POS_W'(ROWS - 1)) &&
                  (col_r == dtx_pkg::DTX_POS_W'(COLS - 1));

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      dtx_pkg::ST_IDLE: begin
        if (in_valid) begin
          state_nxt = seeds_ok ? dtx_pkg::ST_GROW : dtx_pkg::ST_ERR;
        end
      end
      dtx_pkg::ST_GROW: begin
        if (grid_full) begin
          state_nxt = dtx_pkg::ST_EMIT;
        end
      end
      dtx_pkg::ST_EMIT: begin
        if (out_ready && at_end) begin
          state_nxt = dtx_pkg::ST_IDLE;
        end
      end
      dtx_pkg::ST_ERR: begin
        if (out_ready) begin
          state_nxt = dtx_pkg::ST_IDLE;
        end
      end
      default: state_nxt = dtx_pkg::ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    in_ready  = 1'b0;
    out_valid = 1'b0;
    out_err   = 1'b0;
    out_last  = 1'b0;
    ctl       = '0;
    case (state_r)
      dtx_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        ctl.load = in_valid && seeds_ok;
      end
      dtx_pkg::ST_GROW: begin
        ctl.grow = !grid_full;
      end
      dtx_pkg::ST_EMIT: begin
        out_valid = 1'b1;
        out_last  = at_end;
        ctl.shift = out_ready;
      end
      dtx_pkg::ST_ERR: begin
        out_valid = 1'b1;
        out_err   = 1'b1;
        out_last  = 1'b1;
      end
      default: begin
        in_ready = 1'b0;
      end
    endcase
  end

  // row-major readout position
  always_comb begin
    row_nxt = row_r;
    col_nxt = col_r;
    if (state_r == dtx_pkg::ST_EMIT && out_ready) begin
      if (col_r == dtx_pkg::DTX_POS_W'(COLS - 1)) begin
        col_nxt = '0;
        row_nxt = at_end ? '0 : dtx_pkg::DTX_POS_W'(row_r + dtx_pkg::DTX_POS_W'(1));
      end else begin
        col_nxt = dtx_pkg::DTX_POS_W'(col_r + dtx_pkg::DTX_POS_W'(1));
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= dtx_pkg::ST_IDLE;
      row_r   <= '0;
      col_r   <= '0;
    end else begin
      state_r <= state_nxt;
      row_r   <= row_nxt;
      col_r   <= col_nxt;
    end
  end

  assign row = row_r;
  assign col = col_r;

endmodule

/* src/grid_two_seed_distance_transform.sv */
// sequence: the seeds are loaded, the grid grows one generation at a time until it is seen
// full, then the ROWS*COLS results are shifted out at one per cycle while out_tready is high
// no new seed pair is taken until the last result is out; bad seeds give a single error result
// reset: synchronous active-low rst_n clears the grid cells and returns to idle
// top level: grid of dtx_cell instances with a dtx_ctrl sequencer; depends on dtx_pkg
module grid_two_seed_distance_transform #(
  parameter int ROWS = dtx_pkg::DTX_ROWS,
  parameter int COLS = dtx_pkg::DTX_COLS
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  // first_row[3:0], first_col[7:4], second_row[11:8], second_col[15:12]
  input  logic [15:0] in_tdata,
  output logic        out_tvalid,
  input  logic        out_tready,
  // cell_row[2:0], cell_col[5:3], cell_value[9:6], zero[15:10]
  output logic [15:0] out_tdata,
  // seed_error[0]
  output logic        out_tuser,
  // last_cell
  output logic        out_tlast
);

  localparam int NCELL = ROWS * COLS;

  logic [dtx_pkg::DTX_IN_W-1:0] first_row, first_col, second_row, second_col;
  logic [dtx_pkg::DTX_VAL_W-1:0] cell_val [NCELL];
  logic seeds_ok;
  logic grid_full;
  logic out_err;
  logic [dtx_pkg::DTX_POS_W-1:0] row, col;
  dtx_pkg::dtx_ctl_t ctl;

  assign first_row  = in_tdata[3:0];
  assign first_col  = in_tdata[7:4];
  assign second_row = in_tdata[11:8];
  assign second_col = in_tdata[15:12];

  assign seeds_ok = (first_row  < dtx_pkg::DTX_IN_W'(ROWS)) &&
                    (first_col  < dtx_pkg::DTX_IN_W'(COLS)) &&
                    (second_row < dtx_pkg::DTX_IN_W'(ROWS)) &&
                    (second_col < dtx_pkg::DTX_IN_W'(COLS));

  always_comb begin
    grid_full = 1'b1;
    for (int k = 0; k < NCELL; k++) begin
      if (cell_val[k] == '0) begin
        grid_full = 1'b0;
      end
    end
  end

  for (genvar r = 0; r < ROWS; r++) begin : g_row
    for (genvar c = 0; c < COLS; c++) begin : g_col
      localparam int K = r * COLS + c;
      logic [dtx_pkg::DTX_NBR-1:0][dtx_pkg::DTX_VAL_W-1:0] nbr_val;
      logic [dtx_pkg::DTX_VAL_W-1:0] shift_in;
      logic seed;

      for (genvar dr = 0; dr < 3; dr++) begin : g_dr
        for (genvar dc = 0; dc < 3; dc++) begin : g_dc
          localparam int SLOT = dr * 3 + dc;
          localparam int NR = r + dr - 1;
          localparam int NC = c + dc - 1;
          if (SLOT != 4) begin : g_nbr
            localparam int IDX = (SLOT < 4) ? SLOT : SLOT - 1;
            if (NR >= 0 && NR < ROWS && NC >= 0 && NC < COLS) begin : g_in
              assign nbr_val[IDX] = cell_val[NR * COLS + NC];
            end else begin : g_out
              assign nbr_val[IDX] = '0;
            end
          end
        end
      end

      if (K + 1 < NCELL) begin : g_chain
        assign shift_in = cell_val[K + 1];
      end else begin : g_tail
        assign shift_in = '0;
      end

      assign seed = (first_row  == dtx_pkg::DTX_IN_W'(r) && first_col  == dtx_pkg::DTX_IN_W'(c)) ||
                    (second_row == dtx_pkg::DTX_IN_W'(r) && second_col == dtx_pkg::DTX_IN_W'(c));

      dtx_cell u_cell (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctl      (ctl),
        .seed     (seed),
        .nbr_val  (nbr_val),
        .shift_in (shift_in),
        .val      (cell_val[K])
      );
    end
  end

  dtx_ctrl #(
    .ROWS (ROWS),
    .COLS (COLS)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_tvalid),
    .seeds_ok  (seeds_ok),
    .grid_full (grid_full),
    .out_ready (out_tready),
    .in_ready  (in_tready),
    .out_valid (out_tvalid),
    .out_err   (out_err),
    .out_last  (out_tlast),
    .row       (row),
    .col       (col),
    .ctl       (ctl)
  );

  assign out_tdata = {6'd0, (out_err ? {dtx_pkg::DTX_VAL_W{1'b0}} : cell_val[0]), col, row};
  assign out_tuser = out_err;

endmodule

/* src/dtx_checker.sv */
// port-level checks for the two-seed distance transform, bound to the top level
// depends on assert_macros.svh
`include "assert_macros.svh"

module dtx_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [15:0] out_tdata,
  input logic        out_tuser,
  input logic        out_tlast
);

  // one item at a time: no second transaction right after an accept
  `ASSERT_NEXT(a_one_item, in_tvalid && in_tready, !in_tready)

  // no input taken while results are pending
  `ASSERT_SAME(a_no_overlap, out_tvalid, !in_tready)

  // error result is a single, final, all-zero result
  `ASSERT_SAME(a_err_shape, out_tvalid && out_tuser, out_tlast && out_tdata == 16'd0)

  // stalled result holds
  `ASSERT_NEXT(a_hold, out_tvalid && !out_tready,
               out_tvalid && $stable(out_tdata) && $stable(out_tlast))

endmodule

bind grid_two_seed_distance_transform dtx_checker u_dtx_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser),
  .out_tlast  (out_tlast)
);

/* dv/tb.sv */
`timescale 1ns / 100ps
// testbench for grid_two_seed_distance_transform: seed pairs in, grid cells checked out
// a scoreboard class predicts each cell of the grown grid or the error result; depends on dtx_pkg and the rtl
module tb;

  localparam int CYCLE_LIMIT = 500000;
  localparam int TAIL_CYCLES = 80;

  typedef struct packed {
    logic [dtx_pkg::DTX_POS_W-1:0] row;
    logic [dtx_pkg::DTX_POS_W-1:0] col;
    logic [dtx_pkg::DTX_VAL_W-1:0] value;
    logic                          seed_error;
    logic                          last_cell;
  } cell_result_t;

  class distance_scoreboard;
    cell_result_t expected_cells[$];
    int           errors = 0;

    function automatic logic [dtx_pkg::DTX_VAL_W-1:0] least_neighbor(
      logic [dtx_pkg::DTX_VAL_W-1:0] grid [dtx_pkg::DTX_ROWS][dtx_pkg::DTX_COLS],
      int r, int c);
      logic [dtx_pkg::DTX_VAL_W-1:0] best;
      logic [dtx_pkg::DTX_VAL_W-1:0] v;
      int nr;
      int nc;
      best = '0;
      for (int dr = -1; dr <= 1; dr++) begin
        for (int dc = -1; dc <= 1; dc++) begin
          nr = r + dr;
          nc = c + dc;
          if (nr >= 0 && nc >= 0 && nr < dtx_pkg::DTX_ROWS && nc < dtx_pkg::DTX_COLS) begin
            v = grid[nr][nc];
            if (v != 0 && (best == 0 || v < best)) best = v;
          end
        end
      end
      return best;
    endfunction

    function automatic void note_seeds(logic [15:0] d);
      logic [dtx_pkg::DTX_IN_W-1:0]  r1;
      logic [dtx_pkg::DTX_IN_W-1:0]  c1;
      logic [dtx_pkg::DTX_IN_W-1:0]  r2;
      logic [dtx_pkg::DTX_IN_W-1:0]  c2;
      logic [dtx_pkg::DTX_VAL_W-1:0] grid [dtx_pkg::DTX_ROWS][dtx_pkg::DTX_COLS];
      logic [dtx_pkg::DTX_VAL_W-1:0] grown [dtx_pkg::DTX_ROWS][dtx_pkg::DTX_COLS];
      logic [dtx_pkg::DTX_VAL_W-1:0] m;
      cell_result_t                  res;
      bit                            full;
      int                            gen;
      r1 = d[3:0];
      c1 = d[7:4];
      r2 = d[11:8];
      c2 = d[15:12];
      if (r1 >= dtx_pkg::DTX_ROWS || c1 >= dtx_pkg::DTX_COLS ||
          r2 >= dtx_pkg::DTX_ROWS || c2 >= dtx_pkg::DTX_COLS) begin
        res = '{row: '0, col: '0, value: '0, seed_error: 1'b1, last_cell: 1'b1};
        expected_cells.push_back(res);
        return;
      end
      for (int r = 0; r < dtx_pkg::DTX_ROWS; r++)
        for (int c = 0; c < dtx_pkg::DTX_COLS; c++) grid[r][c] = '0;
      grid[r1][c1] = dtx_pkg::DTX_VAL_W'(1);
      grid[r2][c2] = dtx_pkg::DTX_VAL_W'(1);
      gen = 0;
      full = 1'b0;
      while (gen < dtx_pkg::DTX_ROWS * dtx_pkg::DTX_COLS && !full) begin
        full = 1'b1;
        for (int r = 0; r < dtx_pkg::DTX_ROWS; r++)
          for (int c = 0; c < dtx_pkg::DTX_COLS; c++)
            if (grid[r][c] == 0) full = 1'b0;
        if (!full) begin
          grown = grid;
          for (int r = 0; r < dtx_pkg::DTX_ROWS; r++) begin
            for (int c = 0; c < dtx_pkg::DTX_COLS; c++) begin
              if (grid[r][c] == 0) begin
                m = least_neighbor(grid, r, c);
                if (m != 0) grown[r][c] = m + 1'b1;
              end
            end
          end
          grid = grown;
          gen++;
        end
      end
      for (int r = 0; r < dtx_pkg::DTX_ROWS; r++) begin
        for (int c = 0; c < dtx_pkg::DTX_COLS; c++) begin
          res.row        = r[dtx_pkg::DTX_POS_W-1:0];
          res.col        = c[dtx_pkg::DTX_POS_W-1:0];
          res.value      = grid[r][c];
          res.seed_error = 1'b0;
          res.last_cell  = (r == dtx_pkg::DTX_ROWS - 1 && c == dtx_pkg::DTX_COLS - 1);
          expected_cells.push_back(res);
        end
      end
    endfunction

    function automatic void compare_field(string name, int want, int got);
      if (want != got) begin
        $display("%0t: %s mismatch, expected %0d actual %0d", $time, name, want, got);
        errors++;
      end
    endfunction

    function automatic void check_cell(logic [15:0] data, logic user, logic last);
      cell_result_t want;
      if (expected_cells.size() == 0) begin
        $display("%0t: unexpected result, expected none actual tdata=%h tuser=%b tlast=%b",
                 $time, data, user, last);
        errors++;
        return;
      end
      want = expected_cells.pop_front();
      compare_field("cell_row", int'(want.row), int'(data[2:0]));
      compare_field("cell_col", int'(want.col), int'(data[5:3]));
      compare_field("cell_value", int'(want.value), int'(data[9:6]));
      compare_field("tdata padding", 0, int'(data[15:10]));
      compare_field("seed_error", int'(want.seed_error), int'(user));
      compare_field("last_cell", int'(want.last_cell), int'(last));
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [15:0] in_tdata;
  logic        out_tvalid;
  logic        out_tready;
  logic [15:0] out_tdata;
  logic        out_tuser;
  logic        out_tlast;

  int send_idle_pct = 30;
  int recv_idle_pct = 66;
  int cycle_count   = 0;

  distance_scoreboard cell_sb = new();

  grid_two_seed_distance_transform DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser),
    .out_tlast (out_tlast)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  always @(posedge clk) begin
    out_tready <= ($urandom_range(99) >= recv_idle_pct);
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (out_tvalid && out_tready) cell_sb.check_cell(out_tdata, out_tuser, out_tlast);
      if (in_tvalid && in_tready) cell_sb.note_seeds(in_tdata);
    end
  end

  function automatic logic [15:0] pack_seeds(int r1, int c1, int r2, int c2);
    return {c2[3:0], r2[3:0], c1[3:0], r1[3:0]};
  endfunction

  // valid stays high between back-to-back transactions, lowered only to idle
  task automatic send_seeds(logic [15:0] d);
    bit lowered;
    lowered = 1'b0;
    while ($urandom_range(99) < send_idle_pct) begin
      if (!lowered) in_tvalid <= 1'b0;
      lowered = 1'b1;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= d;
    do @(posedge clk); while (!in_tready);
  endtask

  task automatic send_random_seeds();
    logic [15:0] d;
    int          pick;
    int          r1;
    int          c1;
    pick = $urandom_range(99);
    if (pick < 12) begin
      d = 16'($urandom());
      d[4 * $urandom_range(3) + 3] = 1'b1;
    end else if (pick < 18) begin
      r1 = $urandom_range(7);
      c1 = $urandom_range(7);
      d = pack_seeds(r1, c1, r1, c1);
    end else begin
      d = pack_seeds($urandom_range(7), $urandom_range(7),
                     $urandom_range(7), $urandom_range(7));
    end
    send_seeds(d);
  endtask

  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("grid_two_seed_distance_transform test failed");
    $finish;
  end

  initial begin
    rst_n      = 1'b0;
    in_tvalid  = 1'b0;
    in_tdata   = '0;
    out_tready = 1'b0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_seeds(pack_seeds(0, 0, 0, 0));
    send_seeds(pack_seeds(7, 7, 7, 7));
    send_seeds(pack_seeds(0, 0, 7, 7));
    send_seeds(pack_seeds(0, 7, 7, 0));
    send_seeds(pack_seeds(7, 7, 0, 0));
    send_seeds(pack_seeds(3, 4, 3, 4));
    send_seeds(pack_seeds(3, 3, 3, 4));
    send_seeds(pack_seeds(0, 0, 0, 1));
    send_seeds(pack_seeds(7, 0, 7, 7));
    send_seeds(pack_seeds(0, 3, 7, 3));
    send_seeds(pack_seeds(2, 5, 6, 1));
    send_seeds(pack_seeds(8, 0, 0, 0));
    send_seeds(pack_seeds(0, 8, 0, 0));
    send_seeds(pack_seeds(0, 0, 8, 0));
    send_seeds(pack_seeds(0, 0, 0, 8));
    send_seeds(pack_seeds(15, 15, 15, 15));
    send_seeds(pack_seeds(7, 7, 15, 7));
    send_seeds(pack_seeds(5, 2, 1, 6));

    for (int i = 0; i < 87; i++) send_random_seeds();
    send_idle_pct = 66;
    recv_idle_pct = 30;
    for (int i = 0; i < 87; i++) send_random_seeds();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    for (int i = 0; i < 87; i++) send_random_seeds();
    in_tvalid <= 1'b0;

    @(posedge clk);
    while (cell_sb.expected_cells.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (cell_sb.errors == 0) begin
      $display("grid_two_seed_distance_transform test passed");
    end else begin
      $display("grid_two_seed_distance_transform test failed");
    end
    $finish;
  end
endmodule
